// File: rtl/ptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared widths, character codes, token kind codes and the result struct
// used by the punctuation token classifier.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 6;
    localparam int LEN_W  = 2;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef struct packed {
        kind_t kind;
        len_t  length;
    } token_t;

    // character codes
    localparam char_t CH_PLUS    = 8'h2B;
    localparam char_t CH_MINUS   = 8'h2D;
    localparam char_t CH_STAR    = 8'h2A;
    localparam char_t CH_SLASH   = 8'h2F;
    localparam char_t CH_PERCENT = 8'h25;
    localparam char_t CH_CARET   = 8'h5E;
    localparam char_t CH_BANG    = 8'h21;
    localparam char_t CH_TILDE   = 8'h7E;
    localparam char_t CH_EQ      = 8'h3D;
    localparam char_t CH_AMP     = 8'h26;
    localparam char_t CH_PIPE    = 8'h7C;
    localparam char_t CH_LT      = 8'h3C;
    localparam char_t CH_GT      = 8'h3E;
    localparam char_t CH_DOT     = 8'h2E;
    localparam char_t CH_HASH    = 8'h23;
    localparam char_t CH_QUEST   = 8'h3F;
    localparam char_t CH_COMMA   = 8'h2C;
    localparam char_t CH_LPAREN  = 8'h28;
    localparam char_t CH_RPAREN  = 8'h29;
    localparam char_t CH_LBRACK  = 8'h5B;
    localparam char_t CH_RBRACK  = 8'h5D;
    localparam char_t CH_LBRACE  = 8'h7B;
    localparam char_t CH_RBRACE  = 8'h7D;
    localparam char_t CH_SEMI    = 8'h3B;
    localparam char_t CH_COLON   = 8'h3A;

    // token kinds
    localparam kind_t KIND_NONE     = 6'd0;
    localparam kind_t KIND_PLUS     = 6'd1;
    localparam kind_t KIND_MINUS    = 6'd3;
    localparam kind_t KIND_STAR     = 6'd5;
    localparam kind_t KIND_SLASH    = 6'd7;
    localparam kind_t KIND_PERCENT  = 6'd9;
    localparam kind_t KIND_CARET    = 6'd11;
    localparam kind_t KIND_BANG     = 6'd13;
    localparam kind_t KIND_TILDE    = 6'd15;
    localparam kind_t KIND_AMP      = 6'd17;
    localparam kind_t KIND_AMP_EQ   = 6'd18;
    localparam kind_t KIND_AMP_AMP  = 6'd19;
    localparam kind_t KIND_PIPE     = 6'd20;
    localparam kind_t KIND_PIPE_EQ  = 6'd21;
    localparam kind_t KIND_PIPE2    = 6'd22;
    localparam kind_t KIND_LT       = 6'd23;
    localparam kind_t KIND_LT_EQ    = 6'd24;
    localparam kind_t KIND_SHL      = 6'd25;
    localparam kind_t KIND_SHL_EQ   = 6'd26;
    localparam kind_t KIND_GT       = 6'd27;
    localparam kind_t KIND_GT_EQ    = 6'd28;
    localparam kind_t KIND_SHR      = 6'd29;
    localparam kind_t KIND_SHR_EQ   = 6'd30;
    localparam kind_t KIND_DOT      = 6'd31;
    localparam kind_t KIND_ELLIPSIS = 6'd32;
    localparam kind_t KIND_HASH     = 6'd33;
    localparam kind_t KIND_QUEST    = 6'd34;
    localparam kind_t KIND_ASSIGN   = 6'd35;
    localparam kind_t KIND_COMMA    = 6'd37;
    localparam kind_t KIND_LPAREN   = 6'd38;
    localparam kind_t KIND_RPAREN   = 6'd39;
    localparam kind_t KIND_LBRACK   = 6'd40;
    localparam kind_t KIND_RBRACK   = 6'd41;
    localparam kind_t KIND_LBRACE   = 6'd42;
    localparam kind_t KIND_RBRACE   = 6'd43;
    localparam kind_t KIND_SEMI     = 6'd44;
    localparam kind_t KIND_COLON    = 6'd45;

    // token lengths
    localparam len_t LEN_NONE = 2'd0;
    localparam len_t LEN_ONE  = 2'd1;
    localparam len_t LEN_TWO  = 2'd2;
    localparam len_t LEN_THREE = 2'd3;

endpackage

// File: rtl/punctuation_token_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// punctuation_token_classifier
// Classifies C-style punctuation and operators by longest match over a
// three-character window and returns the token kind and length.
// ----------------------------------------------------------------------------
// stages: input register, decode, result register
// throughput: one item per cycle; a held result stalls the input once both
//   registers are full
// reset: rst_n clears both valid flags; payload registers are not reset
// ----------------------------------------------------------------------------
module punctuation_token_classifier
(
    input  logic           clk,
    input  logic           rst_n,

    input  logic           in_valid,
    output logic           in_stall,
    input  ptc_pkg::char_t lead_char,
    input  ptc_pkg::char_t next_char,
    input  ptc_pkg::char_t third_char,

    output logic           out_valid,
    input  logic           out_stall,
    output ptc_pkg::kind_t token_kind,
    output ptc_pkg::len_t  token_length
);

    logic            s1_valid_reg;
    ptc_pkg::char_t  c0_reg;
    ptc_pkg::char_t  c1_reg;
    ptc_pkg::char_t  c2_reg;

    logic            out_valid_reg;
    ptc_pkg::token_t token_reg;
    ptc_pkg::token_t token_next;

    logic            s2_advance;
    logic            s1_advance;

    assign s2_advance = !out_valid_reg || !out_stall;
    assign s1_advance = !s1_valid_reg || s2_advance;
    assign in_stall   = !s1_advance;

    ptc_classify u_classify
    (
        .c0    (c0_reg),
        .c1    (c1_reg),
        .c2    (c2_reg),
        .token (token_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
                s1_valid_reg <= in_valid;
            if (s2_advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && in_valid)
        begin
            c0_reg <= lead_char;
            c1_reg <= next_char;
            c2_reg <= third_char;
        end
        if (s2_advance && s1_valid_reg)
            token_reg <= token_next;
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = token_reg.kind;
    assign token_length = token_reg.length;

    // accepted item lands in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_valid_reg)
        else $error("accepted item lost before decode");

    // a decoded item moves to the result register unless the output holds it back
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_advance |=> out_valid)
        else $error("decoded item lost before result register");

    // no-token and zero length go together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((token_kind == ptc_pkg::KIND_NONE)
                       == (token_length == ptc_pkg::LEN_NONE)))
        else $error("token kind and length disagree");

    // only the three-character forms have length three
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_length == ptc_pkg::LEN_THREE |->
            (token_kind == ptc_pkg::KIND_SHL_EQ || token_kind == ptc_pkg::KIND_SHR_EQ
             || token_kind == ptc_pkg::KIND_ELLIPSIS))
        else $error("bad three-character token");

endmodule

// File: rtl/ptc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_classify
// Longest-match decode of one three-character window into a token kind
// and length.
// ----------------------------------------------------------------------------
module ptc_classify
(
    input  ptc_pkg::char_t  c0,
    input  ptc_pkg::char_t  c1,
    input  ptc_pkg::char_t  c2,
    output ptc_pkg::token_t token
);

    ptc_pkg::kind_t base;
    logic           has_eq_form;

    always_comb
    begin
        base        = ptc_pkg::KIND_NONE;
        has_eq_form = 1'b0;
        token.kind   = ptc_pkg::KIND_NONE;
        token.length = ptc_pkg::LEN_NONE;

        case (c0)
            ptc_pkg::CH_PLUS:    begin base = ptc_pkg::KIND_PLUS;    has_eq_form = 1'b1; end
            ptc_pkg::CH_MINUS:   begin base = ptc_pkg::KIND_MINUS;   has_eq_form = 1'b1; end
            ptc_pkg::CH_STAR:    begin base = ptc_pkg::KIND_STAR;    has_eq_form = 1'b1; end
            ptc_pkg::CH_SLASH:   begin base = ptc_pkg::KIND_SLASH;   has_eq_form = 1'b1; end
            ptc_pkg::CH_PERCENT: begin base = ptc_pkg::KIND_PERCENT; has_eq_form = 1'b1; end
            ptc_pkg::CH_CARET:   begin base = ptc_pkg::KIND_CARET;   has_eq_form = 1'b1; end
            ptc_pkg::CH_BANG:    begin base = ptc_pkg::KIND_BANG;    has_eq_form = 1'b1; end
            ptc_pkg::CH_TILDE:   begin base = ptc_pkg::KIND_TILDE;   has_eq_form = 1'b1; end
            ptc_pkg::CH_EQ:      begin base = ptc_pkg::KIND_ASSIGN;  has_eq_form = 1'b1; end
            ptc_pkg::CH_AMP:
            begin
                token.length = ptc_pkg::LEN_TWO;
                if (c1 == ptc_pkg::CH_EQ)
                    token.kind = ptc_pkg::KIND_AMP_EQ;
                else if (c1 == ptc_pkg::CH_AMP)
                    token.kind = ptc_pkg::KIND_AMP_AMP;
                else
                begin
                    token.kind   = ptc_pkg::KIND_AMP;
                    token.length = ptc_pkg::LEN_ONE;
                end
            end
            ptc_pkg::CH_PIPE:
            begin
                token.length = ptc_pkg::LEN_TWO;
                if (c1 == ptc_pkg::CH_EQ)
                    token.kind = ptc_pkg::KIND_PIPE_EQ;
                else if (c1 == ptc_pkg::CH_PIPE)
                    token.kind = ptc_pkg::KIND_PIPE2;
                else
                begin
                    token.kind   = ptc_pkg::KIND_PIPE;
                    token.length = ptc_pkg::LEN_ONE;
                end
            end
            ptc_pkg::CH_LT:
            begin
                token.length = ptc_pkg::LEN_TWO;
                if (c1 == ptc_pkg::CH_EQ)
                    token.kind = ptc_pkg::KIND_LT_EQ;
                else if (c1 == ptc_pkg::CH_LT)
                begin
                    if (c2 == ptc_pkg::CH_EQ)
                    begin
                        token.kind   = ptc_pkg::KIND_SHL_EQ;
                        token.length = ptc_pkg::LEN_THREE;
                    end
                    else
                        token.kind = ptc_pkg::KIND_SHL;
                end
                else
                begin
                    token.kind   = ptc_pkg::KIND_LT;
                    token.length = ptc_pkg::LEN_ONE;
                end
            end
            ptc_pkg::CH_GT:
            begin
                token.length = ptc_pkg::LEN_TWO;
                if (c1 == ptc_pkg::CH_EQ)
                    token.kind = ptc_pkg::KIND_GT_EQ;
                else if (c1 == ptc_pkg::CH_GT)
                begin
                    if (c2 == ptc_pkg::CH_EQ)
                    begin
                        token.kind   = ptc_pkg::KIND_SHR_EQ;
                        token.length = ptc_pkg::LEN_THREE;
                    end
                    else
                        token.kind = ptc_pkg::KIND_SHR;
                end
                else
                begin
                    token.kind   = ptc_pkg::KIND_GT;
                    token.length = ptc_pkg::LEN_ONE;
                end
            end
            ptc_pkg::CH_DOT:
            begin
                // a lone pair of dots is no token
                if (c1 != ptc_pkg::CH_DOT)
                begin
                    token.kind   = ptc_pkg::KIND_DOT;
                    token.length = ptc_pkg::LEN_ONE;
                end
                else if (c2 == ptc_pkg::CH_DOT)
                begin
                    token.kind   = ptc_pkg::KIND_ELLIPSIS;
                    token.length = ptc_pkg::LEN_THREE;
                end
            end
            ptc_pkg::CH_HASH:   begin token.kind = ptc_pkg::KIND_HASH;   token.length = ptc_pkg::LEN_ONE; end
            ptc_pkg::CH_QUEST:  begin token.kind = ptc_pkg::KIND_QUEST;  token.length = ptc_pkg::LEN_ONE; end
            ptc_pkg::CH_COMMA:  begin token.kind = ptc_pkg::KIND_COMMA;  token.length = ptc_pkg::LEN_ONE; end
            ptc_pkg::CH_LPAREN: begin token.kind = ptc_pkg::KIND_LPAREN; token.length = ptc_pkg::LEN_ONE; end
            ptc_pkg::CH_RPAREN: begin token.kind = ptc_pkg::KIND_RPAREN; token.length = ptc_pkg::LEN_ONE; end
            ptc_pkg::CH_LBRACK: begin token.kind = ptc_pkg::KIND_LBRACK; token.length = ptc_pkg::LEN_ONE; end
            ptc_pkg::CH_RBRACK: begin token.kind = ptc_pkg::KIND_RBRACK; token.length = ptc_pkg::LEN_ONE; end
            ptc_pkg::CH_LBRACE: begin token.kind = ptc_pkg::KIND_LBRACE; token.length = ptc_pkg::LEN_ONE; end
            ptc_pkg::CH_RBRACE: begin token.kind = ptc_pkg::KIND_RBRACE; token.length = ptc_pkg::LEN_ONE; end
            ptc_pkg::CH_SEMI:   begin token.kind = ptc_pkg::KIND_SEMI;   token.length = ptc_pkg::LEN_ONE; end
            ptc_pkg::CH_COLON:  begin token.kind = ptc_pkg::KIND_COLON;  token.length = ptc_pkg::LEN_ONE; end
            default:
            begin
                token.kind   = ptc_pkg::KIND_NONE;
                token.length = ptc_pkg::LEN_NONE;
            end
        endcase

        // bare operator or its compound assignment form
        if (has_eq_form)
        begin
            if (c1 == ptc_pkg::CH_EQ)
            begin
                token.kind   = ptc_pkg::KIND_W'(base + ptc_pkg::kind_t'(1));
                token.length = ptc_pkg::LEN_TWO;
            end
            else
            begin
                token.kind   = base;
                token.length = ptc_pkg::LEN_ONE;
            end
        end
    end

endmodule

// File: test/punctuation_token_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// punctuation_token_classifier_test
// Self-checking bench for the punctuation token classifier. A short table of
// corner windows runs first, then random windows biased toward operator
// characters. Both handshakes idle at random, and every token that comes out
// is checked in order against its table entry or a behavioral classifier.
// ----------------------------------------------------------------------------
module punctuation_token_classifier_test;

    localparam int RANDOM_ITEMS   = 900;
    localparam int QUIET_ITEMS    = 150;
    localparam int PACKED_ITEMS   = 40;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // compound kinds with no name in the package
    localparam ptc_pkg::kind_t KIND_PLUS_EQ    = 6'd2;
    localparam ptc_pkg::kind_t KIND_MINUS_EQ   = 6'd4;
    localparam ptc_pkg::kind_t KIND_STAR_EQ    = 6'd6;
    localparam ptc_pkg::kind_t KIND_SLASH_EQ   = 6'd8;
    localparam ptc_pkg::kind_t KIND_PERCENT_EQ = 6'd10;
    localparam ptc_pkg::kind_t KIND_CARET_EQ   = 6'd12;
    localparam ptc_pkg::kind_t KIND_BANG_EQ    = 6'd14;
    localparam ptc_pkg::kind_t KIND_TILDE_EQ   = 6'd16;
    localparam ptc_pkg::kind_t KIND_EQ_EQ      = 6'd36;

    typedef struct packed {
        ptc_pkg::char_t c0;
        ptc_pkg::char_t c1;
        ptc_pkg::char_t c2;
        bit             known;
        ptc_pkg::kind_t kind;
        ptc_pkg::len_t  length;
    } window_row_t;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    ptc_pkg::char_t lead_char;
    ptc_pkg::char_t next_char;
    ptc_pkg::char_t third_char;
    logic           out_valid;
    logic           out_stall;
    ptc_pkg::kind_t token_kind;
    ptc_pkg::len_t  token_length;

    bit             row_known;
    ptc_pkg::kind_t row_kind;
    ptc_pkg::len_t  row_len;
    bit             hold_req;
    bit             quiet;
    int             errors;
    int             idle_cycles;

    ptc_pkg::token_t pending_tokens[$];
    window_row_t     corner_rows[$];
    ptc_pkg::char_t  punct_set [0:24];

    punctuation_token_classifier uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .lead_char    (lead_char),
        .next_char    (next_char),
        .third_char   (third_char),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_length (token_length)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic ptc_pkg::token_t tok(ptc_pkg::kind_t kind, ptc_pkg::len_t length);
        ptc_pkg::token_t t;
        t.kind   = kind;
        t.length = length;
        return t;
    endfunction

    function automatic ptc_pkg::token_t eq_form(ptc_pkg::char_t c1, ptc_pkg::kind_t bare,
                                                ptc_pkg::kind_t with_eq);
        return (c1 == ptc_pkg::CH_EQ) ? tok(with_eq, ptc_pkg::LEN_TWO)
                                      : tok(bare, ptc_pkg::LEN_ONE);
    endfunction

    function automatic ptc_pkg::token_t classify_window(ptc_pkg::char_t c0,
                                                        ptc_pkg::char_t c1,
                                                        ptc_pkg::char_t c2);
        ptc_pkg::token_t t;
        case (c0)
            ptc_pkg::CH_PLUS:    t = eq_form(c1, ptc_pkg::KIND_PLUS, KIND_PLUS_EQ);
            ptc_pkg::CH_MINUS:   t = eq_form(c1, ptc_pkg::KIND_MINUS, KIND_MINUS_EQ);
            ptc_pkg::CH_STAR:    t = eq_form(c1, ptc_pkg::KIND_STAR, KIND_STAR_EQ);
            ptc_pkg::CH_SLASH:   t = eq_form(c1, ptc_pkg::KIND_SLASH, KIND_SLASH_EQ);
            ptc_pkg::CH_PERCENT: t = eq_form(c1, ptc_pkg::KIND_PERCENT, KIND_PERCENT_EQ);
            ptc_pkg::CH_CARET:   t = eq_form(c1, ptc_pkg::KIND_CARET, KIND_CARET_EQ);
            ptc_pkg::CH_BANG:    t = eq_form(c1, ptc_pkg::KIND_BANG, KIND_BANG_EQ);
            ptc_pkg::CH_TILDE:   t = eq_form(c1, ptc_pkg::KIND_TILDE, KIND_TILDE_EQ);
            ptc_pkg::CH_EQ:      t = eq_form(c1, ptc_pkg::KIND_ASSIGN, KIND_EQ_EQ);
            ptc_pkg::CH_AMP:
                t = (c1 == ptc_pkg::CH_EQ)  ? tok(ptc_pkg::KIND_AMP_EQ, ptc_pkg::LEN_TWO)
                  : (c1 == ptc_pkg::CH_AMP) ? tok(ptc_pkg::KIND_AMP_AMP, ptc_pkg::LEN_TWO)
                  : tok(ptc_pkg::KIND_AMP, ptc_pkg::LEN_ONE);
            ptc_pkg::CH_PIPE:
                t = (c1 == ptc_pkg::CH_EQ)   ? tok(ptc_pkg::KIND_PIPE_EQ, ptc_pkg::LEN_TWO)
                  : (c1 == ptc_pkg::CH_PIPE) ? tok(ptc_pkg::KIND_PIPE2, ptc_pkg::LEN_TWO)
                  : tok(ptc_pkg::KIND_PIPE, ptc_pkg::LEN_ONE);
            ptc_pkg::CH_LT:
                t = (c1 == ptc_pkg::CH_EQ) ? tok(ptc_pkg::KIND_LT_EQ, ptc_pkg::LEN_TWO)
                  : (c1 != ptc_pkg::CH_LT) ? tok(ptc_pkg::KIND_LT, ptc_pkg::LEN_ONE)
                  : (c2 == ptc_pkg::CH_EQ) ? tok(ptc_pkg::KIND_SHL_EQ, ptc_pkg::LEN_THREE)
                  : tok(ptc_pkg::KIND_SHL, ptc_pkg::LEN_TWO);
            ptc_pkg::CH_GT:
                t = (c1 == ptc_pkg::CH_EQ) ? tok(ptc_pkg::KIND_GT_EQ, ptc_pkg::LEN_TWO)
                  : (c1 != ptc_pkg::CH_GT) ? tok(ptc_pkg::KIND_GT, ptc_pkg::LEN_ONE)
                  : (c2 == ptc_pkg::CH_EQ) ? tok(ptc_pkg::KIND_SHR_EQ, ptc_pkg::LEN_THREE)
                  : tok(ptc_pkg::KIND_SHR, ptc_pkg::LEN_TWO);
            // a bare pair of dots is no token at all
            ptc_pkg::CH_DOT:
                t = (c1 != ptc_pkg::CH_DOT) ? tok(ptc_pkg::KIND_DOT, ptc_pkg::LEN_ONE)
                  : (c2 == ptc_pkg::CH_DOT) ? tok(ptc_pkg::KIND_ELLIPSIS, ptc_pkg::LEN_THREE)
                  : tok(ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE);
            ptc_pkg::CH_HASH:   t = tok(ptc_pkg::KIND_HASH, ptc_pkg::LEN_ONE);
            ptc_pkg::CH_QUEST:  t = tok(ptc_pkg::KIND_QUEST, ptc_pkg::LEN_ONE);
            ptc_pkg::CH_COMMA:  t = tok(ptc_pkg::KIND_COMMA, ptc_pkg::LEN_ONE);
            ptc_pkg::CH_LPAREN: t = tok(ptc_pkg::KIND_LPAREN, ptc_pkg::LEN_ONE);
            ptc_pkg::CH_RPAREN: t = tok(ptc_pkg::KIND_RPAREN, ptc_pkg::LEN_ONE);
            ptc_pkg::CH_LBRACK: t = tok(ptc_pkg::KIND_LBRACK, ptc_pkg::LEN_ONE);
            ptc_pkg::CH_RBRACK: t = tok(ptc_pkg::KIND_RBRACK, ptc_pkg::LEN_ONE);
            ptc_pkg::CH_LBRACE: t = tok(ptc_pkg::KIND_LBRACE, ptc_pkg::LEN_ONE);
            ptc_pkg::CH_RBRACE: t = tok(ptc_pkg::KIND_RBRACE, ptc_pkg::LEN_ONE);
            ptc_pkg::CH_SEMI:   t = tok(ptc_pkg::KIND_SEMI, ptc_pkg::LEN_ONE);
            ptc_pkg::CH_COLON:  t = tok(ptc_pkg::KIND_COLON, ptc_pkg::LEN_ONE);
            default:            t = tok(ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE);
        endcase
        return t;
    endfunction

    // mostly operator characters, some one bit off, some fully random
    function automatic ptc_pkg::char_t pick_char();
        ptc_pkg::char_t c;
        c = punct_set[$urandom_range(0, 24)];
        case ($urandom_range(0, 7))
            0, 1:    c = ptc_pkg::char_t'($urandom_range(0, 255));
            2:       c = c ^ (ptc_pkg::char_t'(1) << $urandom_range(0, 7));
            default: ;
        endcase
        return c;
    endfunction

    task automatic offer(input ptc_pkg::char_t c0, input ptc_pkg::char_t c1,
                         input ptc_pkg::char_t c2, input bit known,
                         input ptc_pkg::kind_t kind, input ptc_pkg::len_t length);
        in_valid   <= 1'b1;
        lead_char  <= c0;
        next_char  <= c1;
        third_char <= c2;
        row_known  <= known;
        row_kind   <= kind;
        row_len    <= length;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_tokens.size() != 0);
    endtask

    // scoreboard and watchdog
    always @(posedge clk)
    begin
        ptc_pkg::token_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                pending_tokens.push_back(row_known ? tok(row_kind, row_len)
                                         : classify_window(lead_char, next_char, third_char));
            if (out_valid && !out_stall)
            begin
                if (pending_tokens.size() == 0)
                begin
                    $display("%0t: unexpected token kind %0d length %0d",
                             $time, token_kind, token_length);
                    errors++;
                end
                else
                begin
                    want = pending_tokens.pop_front();
                    if (token_kind !== want.kind)
                    begin
                        $display("%0t: token_kind expected %0d actual %0d",
                                 $time, want.kind, token_kind);
                        errors++;
                    end
                    if (token_length !== want.length)
                    begin
                        $display("%0t: token_length expected %0d actual %0d",
                                 $time, want.length, token_length);
                        errors++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver
    initial
    begin
        bit stalling;
        int burst_left;
        out_stall  = 1'b0;
        stalling   = 1'b0;
        burst_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else
            begin
                if (burst_left == 0)
                begin
                    stalling   = ($urandom_range(0, 2) == 0);
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;
                out_stall <= stalling;
            end
        end
    end

    // sender
    initial
    begin
        window_row_t    row;
        ptc_pkg::char_t c0;
        ptc_pkg::char_t c1;
        ptc_pkg::char_t c2;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        lead_char   = '0;
        next_char   = '0;
        third_char  = '0;
        row_known   = 1'b0;
        row_kind    = ptc_pkg::KIND_NONE;
        row_len     = ptc_pkg::LEN_NONE;
        hold_req    = 1'b0;
        quiet       = 1'b0;
        errors      = 0;
        idle_cycles = 0;
        punct_set = '{ptc_pkg::CH_PLUS, ptc_pkg::CH_MINUS, ptc_pkg::CH_STAR,
                      ptc_pkg::CH_SLASH, ptc_pkg::CH_PERCENT, ptc_pkg::CH_CARET,
                      ptc_pkg::CH_BANG, ptc_pkg::CH_TILDE, ptc_pkg::CH_EQ,
                      ptc_pkg::CH_AMP, ptc_pkg::CH_PIPE, ptc_pkg::CH_LT, ptc_pkg::CH_GT,
                      ptc_pkg::CH_DOT, ptc_pkg::CH_HASH, ptc_pkg::CH_QUEST,
                      ptc_pkg::CH_COMMA, ptc_pkg::CH_LPAREN, ptc_pkg::CH_RPAREN,
                      ptc_pkg::CH_LBRACK, ptc_pkg::CH_RBRACK, ptc_pkg::CH_LBRACE,
                      ptc_pkg::CH_RBRACE, ptc_pkg::CH_SEMI, ptc_pkg::CH_COLON};

        corner_rows.push_back('{8'h00, 8'h00, 8'h00, 1'b1,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{8'hFF, 8'hFF, 8'hFF, 1'b1,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_LT, ptc_pkg::CH_LT, ptc_pkg::CH_EQ, 1'b1,
                                ptc_pkg::KIND_SHL_EQ, ptc_pkg::LEN_THREE});
        corner_rows.push_back('{ptc_pkg::CH_GT, ptc_pkg::CH_GT, ptc_pkg::CH_EQ, 1'b1,
                                ptc_pkg::KIND_SHR_EQ, ptc_pkg::LEN_THREE});
        corner_rows.push_back('{ptc_pkg::CH_DOT, ptc_pkg::CH_DOT, ptc_pkg::CH_DOT, 1'b1,
                                ptc_pkg::KIND_ELLIPSIS, ptc_pkg::LEN_THREE});
        corner_rows.push_back('{ptc_pkg::CH_DOT, ptc_pkg::CH_DOT, 8'h00, 1'b1,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_DOT, ptc_pkg::CH_DOT, ptc_pkg::CH_EQ, 1'b1,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_COLON, 8'hFF, 8'hFF, 1'b1,
                                ptc_pkg::KIND_COLON, ptc_pkg::LEN_ONE});
        corner_rows.push_back('{ptc_pkg::CH_PLUS, 8'h00, 8'h00, 1'b1,
                                ptc_pkg::KIND_PLUS, ptc_pkg::LEN_ONE});
        corner_rows.push_back('{ptc_pkg::CH_EQ | 8'h80, ptc_pkg::CH_EQ, ptc_pkg::CH_EQ, 1'b1,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_HASH, ptc_pkg::CH_EQ, ptc_pkg::CH_EQ, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_DOT, ptc_pkg::CH_EQ, ptc_pkg::CH_DOT, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_AMP, ptc_pkg::CH_AMP, ptc_pkg::CH_EQ, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_AMP, ptc_pkg::CH_EQ, 8'h00, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_PIPE, ptc_pkg::CH_PIPE, ptc_pkg::CH_EQ, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_PIPE, ptc_pkg::CH_EQ, 8'hFF, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_LT, ptc_pkg::CH_EQ, ptc_pkg::CH_EQ, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_LT, ptc_pkg::CH_LT, 8'hFF, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_GT, ptc_pkg::CH_EQ, 8'h00, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_GT, 8'h00, ptc_pkg::CH_EQ, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_EQ, ptc_pkg::CH_EQ, ptc_pkg::CH_EQ, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_BANG, ptc_pkg::CH_EQ, 8'h00, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_TILDE, ptc_pkg::CH_EQ, 8'hFF, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_SLASH, ptc_pkg::CH_SLASH, ptc_pkg::CH_EQ, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});
        corner_rows.push_back('{ptc_pkg::CH_QUEST, 8'h80, 8'h7F, 1'b0,
                                ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE});

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        foreach (corner_rows[i])
        begin
            row = corner_rows[i];
            offer(row.c0, row.c1, row.c2, row.known, row.kind, row.length);
            if ($urandom_range(0, 3) == 0)
                idle($urandom_range(1, 16));
        end
        wait_drained();

        // long receiver hold-off while windows keep coming back to back
        hold_req = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            else if (i >= PACKED_ITEMS && i < RANDOM_ITEMS - QUIET_ITEMS
                     && $urandom_range(0, 4) == 0)
                idle($urandom_range(1, 16));
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            c0 = pick_char();
            case ($urandom_range(0, 3))
                0:       c1 = ptc_pkg::CH_EQ;
                1:       c1 = c0;
                default: c1 = pick_char();
            endcase
            case ($urandom_range(0, 3))
                0:       c2 = ptc_pkg::CH_EQ;
                1:       c2 = c1;
                default: c2 = pick_char();
            endcase
            offer(c0, c1, c2, 1'b0, ptc_pkg::KIND_NONE, ptc_pkg::LEN_NONE);
        end
        in_valid <= 1'b0;

        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_tokens.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
